[src/cia_pkg.sv]
// Shared types, codes and width helpers for the checked integer ALU.
package cia_pkg;

  localparam logic [4:0] CMD_ADD = 5'd0;
  localparam logic [4:0] CMD_SUB = 5'd1;
  localparam logic [4:0] CMD_MUL = 5'd2;
  localparam logic [4:0] CMD_DIV = 5'd3;
  localparam logic [4:0] CMD_REM = 5'd4;
  localparam logic [4:0] CMD_OR  = 5'd5;
  localparam logic [4:0] CMD_XOR = 5'd6;
  localparam logic [4:0] CMD_AND = 5'd7;
  localparam logic [4:0] CMD_SHL = 5'd8;
  localparam logic [4:0] CMD_SHR = 5'd9;
  localparam logic [4:0] CMD_LT  = 5'd10;
  localparam logic [4:0] CMD_LE  = 5'd11;
  localparam logic [4:0] CMD_GT  = 5'd12;
  localparam logic [4:0] CMD_GE  = 5'd13;
  localparam logic [4:0] CMD_EQ  = 5'd14;
  localparam logic [4:0] CMD_NE  = 5'd15;
  localparam logic [4:0] CMD_NEG = 5'd16;
  localparam logic [4:0] CMD_NOT = 5'd17;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_DIV0  = 2'd2;
  localparam logic [1:0] ST_SHIFT = 2'd3;

  localparam int DIV_STAGES = 64;
  localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [4:0]  command;
    logic        is_signed;
    logic [1:0]  width_select;
    logic [63:0] left_operand;
    logic [63:0] right_operand;
  } req_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        is_boolean;
    logic [1:0]  status;
  } rsp_t;

  // Everything the back end needs besides the divider datapath.
  typedef struct packed {
    logic       is_div;
    logic       is_rem;
    logic       sgn;
    logic [1:0] wsel;
    logic       div_zero;
    logic       min_neg1;
    logic       na;
    logic       nb;
    rsp_t       early;
  } side_t;

  typedef struct packed {
    logic [63:0] dividend;
    logic [63:0] divisor;
    side_t       side;
  } div_req_t;

  function automatic logic [63:0] wmask(input logic [1:0] w);
    logic [63:0] m;
    case (w)
      2'd0:    m = 64'h0000_0000_0000_00FF;
      2'd1:    m = 64'h0000_0000_0000_FFFF;
      2'd2:    m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  function automatic logic [6:0] wbits(input logic [1:0] w);
    return 7'd8 << w;
  endfunction

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] w);
    logic [63:0] r;
    case (w)
      2'd0:    r = {{56{v[7]}}, v[7:0]};
      2'd1:    r = {{48{v[15]}}, v[15:0]};
      2'd2:    r = {{32{v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  function automatic logic fits(input logic [63:0] v, input logic sgn, input logic [1:0] w);
    return sgn ? (v == sext(v, w)) : ((v & ~wmask(w)) == 64'd0);
  endfunction

endpackage

[src/cia_chan_if.sv]
// Valid/ready channel carrying one payload per transaction.
interface cia_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[src/checked_integer_alu_unit.sv]
// Top level of the overflow-checked integer ALU pipeline.
// Usage:
//   req: one transaction per operation (command, is_signed, width_select,
//        left_operand, right_operand); accepted when valid and ready are high.
//   rsp: one transaction per operation, in order (result_value, is_boolean,
//        status). Errors give a zero result and a nonzero status.
// Path: 6 front stages for decode, simple ops and the 64x64 multiply, 64
//   divider stages at one quotient bit each, and the output register.
//   Every operation takes the same path, so results leave in order.
// Throughput: one transaction per cycle while rsp is not held off; the
//   pipeline holds up to 71 of them.
// Stall: all stages advance together whenever the output register is empty or
//   being taken. While rsp is held off, req.ready drops and every stage
//   freezes, so nothing is lost or repeated.
// Reset: synchronous rst clears all valid bits; payload registers are not
//   reset. The block is ready the cycle after reset is released.
module checked_integer_alu_unit (
  input logic       clk,
  input logic       rst,
  cia_chan_if.sink  req,
  cia_chan_if.source rsp
);

  // global advance: output slot free or draining
  logic en;
  assign en        = !rsp.valid || rsp.ready;
  assign req.ready = en;

  logic              front_valid;
  cia_pkg::div_req_t front_data;

  cia_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (req.valid),
    .in_data   (req.payload),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  logic           div_valid;
  logic [63:0]    quo;
  logic [63:0]    rem;
  cia_pkg::side_t side;

  cia_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (div_valid),
    .quotient  (quo),
    .remainder (rem),
    .out_side  (side)
  );

  // div/rem sign fixup and range check; other ops pass their early result
  logic [63:0]   dval;
  logic [1:0]    dst;
  cia_pkg::rsp_t fin;

  always_comb begin
    dst  = cia_pkg::ST_OK;
    dval = 64'd0;
    if (side.div_zero) begin
      dst = cia_pkg::ST_DIV0;
    end else if (side.min_neg1) begin
      // signed minimum by minus one: quotient overflows, remainder is zero
      if (side.is_div) dst = cia_pkg::ST_OVF;
    end else begin
      if (side.is_div) begin
        dval = (side.na ^ side.nb) ? (64'd0 - quo) : quo;
      end else begin
        dval = side.na ? (64'd0 - rem) : rem;
      end
      if (!cia_pkg::fits(dval, side.sgn, side.wsel)) dst = cia_pkg::ST_OVF;
    end
    if (side.is_div || side.is_rem) begin
      fin.status       = dst;
      fin.is_boolean   = 1'b0;
      fin.result_value = (dst == cia_pkg::ST_OK) ? (dval & cia_pkg::wmask(side.wsel))
                                                 : 64'd0;
    end else begin
      fin = side.early;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en) begin
      rsp.valid <= div_valid;
    end
    if (en) begin
      rsp.payload <= fin;
    end
  end

  // compare results are clean truth values
  a_bool_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.is_boolean) |->
      (rsp.payload.status == cia_pkg::ST_OK && rsp.payload.result_value[63:1] == 63'd0))
    else $error("boolean result with bad status or value");

  // any error zeroes the result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.payload.status != cia_pkg::ST_OK) |->
      (rsp.payload.result_value == 64'd0 && !rsp.payload.is_boolean))
    else $error("error status with nonzero result");

  // a held output freezes intake
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |-> !req.ready)
    else $error("input accepted while output stalled");

  // divider stage output only reaches rsp through an advance
  a_adv: assert property (@(posedge clk) disable iff (rst)
    (div_valid && en) |=> rsp.valid)
    else $error("divider result dropped");

endmodule

[src/cia_front.sv]
// Front pipeline: operand decode, simple ops, staged 64x64 multiply, divider setup.
module cia_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cia_pkg::req_t     in_data,
  output logic              out_valid,
  output cia_pkg::div_req_t out_data
);

  typedef struct packed {
    logic [4:0]  cmd;
    logic        sgn;
    logic [1:0]  wsel;
    logic [63:0] ma;
    logic [63:0] mb;
    logic        na;
    logic        nb;
    logic        dz;
    logic        mn;
    logic        mneg;
    logic        mzero;
  } op_t;

  // stage 1: extended operands
  logic        v1;
  logic [4:0]  c1;
  logic        s1;
  logic [1:0]  w1;
  logic [63:0] a1;
  logic [63:0] b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      c1 <= in_data.command;
      s1 <= in_data.is_signed;
      w1 <= in_data.width_select;
      a1 <= in_data.is_signed ? cia_pkg::sext(in_data.left_operand, in_data.width_select)
                              : (in_data.left_operand & cia_pkg::wmask(in_data.width_select));
      b1 <= in_data.is_signed ? cia_pkg::sext(in_data.right_operand, in_data.width_select)
                              : (in_data.right_operand & cia_pkg::wmask(in_data.width_select));
    end
  end

  // simple ops, raw result and early status
  logic [64:0] sum1;
  logic [63:0] diff1;
  logic [63:0] ovf_add_v;
  logic [63:0] ovf_sub_v;
  logic [63:0] maxv1;
  logic        shift_bad;
  logic        lt_ab;
  logic        lt_ba;
  logic [63:0] raw1;
  logic [1:0]  st1;
  logic        bl1;
  op_t         op1;

  assign sum1      = {1'b0, a1} + {1'b0, b1};
  assign diff1     = a1 - b1;
  assign ovf_add_v = (a1 ^ sum1[63:0]) & (b1 ^ sum1[63:0]);
  assign ovf_sub_v = (a1 ^ b1) & (a1 ^ diff1);
  assign maxv1     = s1 ? (cia_pkg::wmask(w1) >> 1) : cia_pkg::wmask(w1);
  assign shift_bad = (s1 && b1[63]) || (b1 >= {57'd0, cia_pkg::wbits(w1)});
  assign lt_ab     = s1 ? ($signed(a1) < $signed(b1)) : (a1 < b1);
  assign lt_ba     = s1 ? ($signed(b1) < $signed(a1)) : (b1 < a1);

  always_comb begin
    raw1 = 64'd0;
    st1  = cia_pkg::ST_OK;
    bl1  = 1'b0;
    case (c1)
      cia_pkg::CMD_ADD: begin
        raw1 = sum1[63:0];
        if (s1 ? ovf_add_v[63] : sum1[64]) st1 = cia_pkg::ST_OVF;
      end
      cia_pkg::CMD_SUB: begin
        raw1 = diff1;
        if (s1 ? ovf_sub_v[63] : (a1 < b1)) st1 = cia_pkg::ST_OVF;
      end
      cia_pkg::CMD_MUL, cia_pkg::CMD_DIV, cia_pkg::CMD_REM: raw1 = 64'd0;
      cia_pkg::CMD_OR:  raw1 = a1 | b1;
      cia_pkg::CMD_XOR: raw1 = a1 ^ b1;
      cia_pkg::CMD_AND: raw1 = a1 & b1;
      cia_pkg::CMD_SHL: begin
        if (shift_bad) begin
          st1 = cia_pkg::ST_SHIFT;
        end else if (s1 && a1[63]) begin
          st1 = cia_pkg::ST_OVF;
        end else if ((b1 != 64'd0) && (a1 > (maxv1 >> b1[5:0]))) begin
          st1 = cia_pkg::ST_OVF;
        end else begin
          raw1 = a1 << b1[5:0];
        end
      end
      cia_pkg::CMD_SHR: begin
        if (shift_bad) begin
          st1 = cia_pkg::ST_SHIFT;
        end else begin
          raw1 = s1 ? 64'($signed(a1) >>> b1[5:0]) : (a1 >> b1[5:0]);
        end
      end
      cia_pkg::CMD_LT: begin raw1 = {63'd0, lt_ab};  bl1 = 1'b1; end
      cia_pkg::CMD_LE: begin raw1 = {63'd0, !lt_ba}; bl1 = 1'b1; end
      cia_pkg::CMD_GT: begin raw1 = {63'd0, lt_ba};  bl1 = 1'b1; end
      cia_pkg::CMD_GE: begin raw1 = {63'd0, !lt_ab}; bl1 = 1'b1; end
      cia_pkg::CMD_EQ: begin raw1 = {63'd0, a1 == b1}; bl1 = 1'b1; end
      cia_pkg::CMD_NE: begin raw1 = {63'd0, a1 != b1}; bl1 = 1'b1; end
      cia_pkg::CMD_NEG: begin
        if (!s1) begin
          if (a1 != 64'd0) st1 = cia_pkg::ST_OVF;
        end else if (a1 == cia_pkg::SIGN64) begin
          st1 = cia_pkg::ST_OVF;
        end else begin
          raw1 = 64'd0 - a1;
        end
      end
      cia_pkg::CMD_NOT: raw1 = s1 ? ~a1 : (~a1 & cia_pkg::wmask(w1));
      default: st1 = cia_pkg::ST_OVF;
    endcase
  end

  always_comb begin
    op1.cmd   = c1;
    op1.sgn   = s1;
    op1.wsel  = w1;
    op1.na    = s1 && a1[63];
    op1.nb    = s1 && b1[63];
    op1.ma    = (s1 && a1[63]) ? (64'd0 - a1) : a1;
    op1.mb    = (s1 && b1[63]) ? (64'd0 - b1) : b1;
    op1.dz    = (b1 == 64'd0);
    op1.mn    = s1 && (a1 == cia_pkg::SIGN64) && (b1 == '1);
    op1.mneg  = s1 && (a1[63] ^ b1[63]);
    op1.mzero = (a1 == 64'd0) || (b1 == 64'd0);
  end

  // stage 2
  logic        v2;
  op_t         op2;
  logic [63:0] raw2;
  logic [1:0]  st2;
  logic        bl2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2  <= op1;
      raw2 <= raw1;
      st2  <= st1;
      bl2  <= bl1;
    end
  end

  // simple result finish, partial products
  cia_pkg::rsp_t simple2;
  logic [1:0]    st2f;

  always_comb begin
    st2f = st2;
    if ((st2 == cia_pkg::ST_OK) && !bl2 && !cia_pkg::fits(raw2, op2.sgn, op2.wsel)) begin
      st2f = cia_pkg::ST_OVF;
    end
    simple2.status       = st2f;
    simple2.is_boolean   = (st2f == cia_pkg::ST_OK) && bl2;
    simple2.result_value = (st2f == cia_pkg::ST_OK) ? (raw2 & cia_pkg::wmask(op2.wsel))
                                                    : 64'd0;
  end

  // stage 3
  logic          v3;
  op_t           op3;
  cia_pkg::rsp_t simple3;
  logic [63:0]   ll3, lh3, hl3, hh3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3     <= op2;
      simple3 <= simple2;
      ll3     <= op2.ma[31:0]  * op2.mb[31:0];
      lh3     <= op2.ma[31:0]  * op2.mb[63:32];
      hl3     <= op2.ma[63:32] * op2.mb[31:0];
      hh3     <= op2.ma[63:32] * op2.mb[63:32];
    end
  end

  // stage 4: middle sum
  logic          v4;
  op_t           op4;
  cia_pkg::rsp_t simple4;
  logic [63:0]   ll4, hh4;
  logic [64:0]   mid4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
    if (en) begin
      op4     <= op3;
      simple4 <= simple3;
      ll4     <= ll3;
      hh4     <= hh3;
      mid4    <= {1'b0, lh3} + {1'b0, hl3};
    end
  end

  // stage 5: full product
  logic          v5;
  op_t           op5;
  cia_pkg::rsp_t simple5;
  logic [127:0]  p5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
    if (en) begin
      op5     <= op4;
      simple5 <= simple4;
      p5      <= {hh4, 64'd0} + {31'd0, mid4, 32'd0} + {64'd0, ll4};
    end
  end

  // product range check and sign, result select
  logic [63:0]   lim5;
  logic          movf5;
  logic [63:0]   mval5;
  cia_pkg::rsp_t mul5;
  cia_pkg::rsp_t early5;
  logic          is_mul5;

  assign lim5    = (cia_pkg::wmask(op5.wsel) >> 1) + 64'd1;
  assign is_mul5 = (op5.cmd == cia_pkg::CMD_MUL);

  always_comb begin
    if (op5.mzero) begin
      movf5 = 1'b0;
    end else if (!op5.sgn) begin
      movf5 = (p5[127:64] != 64'd0) || ((p5[63:0] & ~cia_pkg::wmask(op5.wsel)) != 64'd0);
    end else if (op5.mneg) begin
      movf5 = (p5[127:64] != 64'd0) || (p5[63:0] > lim5);
    end else begin
      movf5 = (p5[127:64] != 64'd0) || (p5[63:0] >= lim5);
    end
    mval5 = op5.mneg ? (64'd0 - p5[63:0]) : p5[63:0];
    mul5.is_boolean   = 1'b0;
    mul5.status       = movf5 ? cia_pkg::ST_OVF : cia_pkg::ST_OK;
    mul5.result_value = (movf5 || op5.mzero) ? 64'd0 : (mval5 & cia_pkg::wmask(op5.wsel));
    early5 = is_mul5 ? mul5 : simple5;
  end

  // stage 6: handoff to divider
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
    if (en) begin
      out_data.dividend      <= op5.ma;
      out_data.divisor       <= op5.mb;
      out_data.side.is_div   <= (op5.cmd == cia_pkg::CMD_DIV);
      out_data.side.is_rem   <= (op5.cmd == cia_pkg::CMD_REM);
      out_data.side.sgn      <= op5.sgn;
      out_data.side.wsel     <= op5.wsel;
      out_data.side.div_zero <= op5.dz;
      out_data.side.min_neg1 <= op5.mn;
      out_data.side.na       <= op5.na;
      out_data.side.nb       <= op5.nb;
      out_data.side.early    <= early5;
    end
  end

endmodule

[src/cia_divider.sv]
// Restoring divider, one quotient bit per pipeline stage.
module cia_divider (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  cia_pkg::div_req_t in_data,
  output logic              out_valid,
  output logic [63:0]       quotient,
  output logic [63:0]       remainder,
  output cia_pkg::side_t    out_side
);

  logic [63:0]    rem_r  [cia_pkg::DIV_STAGES];
  logic [63:0]    quo_r  [cia_pkg::DIV_STAGES];
  logic [63:0]    dvs_r  [cia_pkg::DIV_STAGES];
  cia_pkg::side_t side_r [cia_pkg::DIV_STAGES];
  logic [cia_pkg::DIV_STAGES-1:0] vld;

  for (genvar g = 0; g < cia_pkg::DIV_STAGES; g++) begin : g_stage
    logic [63:0]    rem_in;
    logic [63:0]    quo_in;
    logic [63:0]    dvs_in;
    cia_pkg::side_t side_in;
    logic           vld_in;
    logic [64:0]    trial;
    logic           qbit;

    if (g == 0) begin : g_first
      assign rem_in  = 64'd0;
      assign quo_in  = in_data.dividend;
      assign dvs_in  = in_data.divisor;
      assign side_in = in_data.side;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[g-1];
      assign quo_in  = quo_r[g-1];
      assign dvs_in  = dvs_r[g-1];
      assign side_in = side_r[g-1];
      assign vld_in  = vld[g-1];
    end

    assign trial = {rem_in, quo_in[63]} - {1'b0, dvs_in};
    assign qbit  = !trial[64];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (en) begin
        vld[g] <= vld_in;
      end
      if (en) begin
        rem_r[g]  <= qbit ? trial[63:0] : {rem_in[62:0], quo_in[63]};
        quo_r[g]  <= {quo_in[62:0], qbit};
        dvs_r[g]  <= dvs_in;
        side_r[g] <= side_in;
      end
    end
  end

  assign out_valid = vld[cia_pkg::DIV_STAGES-1];
  assign quotient  = quo_r[cia_pkg::DIV_STAGES-1];
  assign remainder = rem_r[cia_pkg::DIV_STAGES-1];
  assign out_side  = side_r[cia_pkg::DIV_STAGES-1];

endmodule

[tb/checked_integer_alu_unit_test.sv]
// Self-checking testbench for the checked integer ALU unit.
`timescale 1ns / 1ps

module checked_integer_alu_unit_test;

  // Cycles with no transaction on either channel before the run is declared hung.
  // The limit must cover the pipeline latency plus the random stalls on both sides.
  localparam int HANG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 500;
  // Cycles to wait after the last result, in case the block still holds something.
  localparam int TAIL_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cia_chan_if #(.payload_t(cia_pkg::req_t)) req ();
  cia_chan_if #(.payload_t(cia_pkg::rsp_t)) rsp ();

  checked_integer_alu_unit uut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Keeps the expected responses in order and predicts each one from the
  // request transaction that causes it.
  class result_scoreboard;
    cia_pkg::rsp_t expected_q[$];
    int   errors;
    int   checked;

    function new();
      errors = 0;
      checked = 0;
    endfunction

    // Sign-fills a pattern from the selected width up to 64 bits.
    function logic [63:0] sign_fill(logic [63:0] v, logic [1:0] wsel);
      int sh;
      logic signed [63:0] t;
      sh = 64 - (8 << wsel);
      t = v << sh;
      return t >>> sh;
    endfunction

    function cia_pkg::rsp_t predict_alu(cia_pkg::req_t q);
      cia_pkg::rsp_t o;
      logic [63:0] mask, a, b, r, ma, mb, maxv, quo;
      logic [127:0] prod;
      logic        sgn, boolean, ovf_neg;
      logic [1:0]  st;
      int          w;
      sgn = q.is_signed;
      w = 8 << q.width_select;
      mask = (q.width_select == 2'd3) ? '1 : ((64'd1 << w) - 64'd1);
      a = sgn ? sign_fill(q.left_operand, q.width_select) : (q.left_operand & mask);
      b = sgn ? sign_fill(q.right_operand, q.width_select) : (q.right_operand & mask);
      r = '0;
      boolean = 1'b0;
      st = cia_pkg::ST_OK;
      ma = (sgn && a[63]) ? -a : a;
      mb = (sgn && b[63]) ? -b : b;
      case (q.command)
        cia_pkg::CMD_ADD: begin
          r = a + b;
          if (sgn ? ((a ^ r) & (b ^ r)) >> 63 != 0 : r < a) st = cia_pkg::ST_OVF;
        end
        cia_pkg::CMD_SUB: begin
          r = a - b;
          if (sgn ? ((a ^ b) & (a ^ r)) >> 63 != 0 : a < b) st = cia_pkg::ST_OVF;
        end
        cia_pkg::CMD_MUL: begin
          if (a != 0 && b != 0) begin
            prod = {64'd0, ma} * {64'd0, mb};
            if (prod[127:64] != 0) begin
              st = cia_pkg::ST_OVF;
            end else if (sgn) begin
              ovf_neg = a[63] ^ b[63];
              if (ovf_neg ? prod[63:0] > cia_pkg::SIGN64 : prod[63:0] >= cia_pkg::SIGN64)
                st = cia_pkg::ST_OVF;
              else r = ovf_neg ? -prod[63:0] : prod[63:0];
            end else begin
              r = prod[63:0];
            end
          end
        end
        cia_pkg::CMD_DIV, cia_pkg::CMD_REM: begin
          if (b == 0) begin
            st = cia_pkg::ST_DIV0;
          end else if (sgn) begin
            if (a == cia_pkg::SIGN64 && b == '1) begin
              // MIN / -1 cannot be represented; MIN % -1 is simply zero
              if (q.command == cia_pkg::CMD_DIV) st = cia_pkg::ST_OVF;
            end else if (q.command == cia_pkg::CMD_DIV) begin
              quo = ma / mb;
              r = (a[63] != b[63]) ? -quo : quo;
            end else begin
              quo = ma % mb;
              r = a[63] ? -quo : quo;
            end
          end else begin
            r = (q.command == cia_pkg::CMD_DIV) ? a / b : a % b;
          end
        end
        cia_pkg::CMD_OR:  r = a | b;
        cia_pkg::CMD_XOR: r = a ^ b;
        cia_pkg::CMD_AND: r = a & b;
        cia_pkg::CMD_SHL, cia_pkg::CMD_SHR: begin
          // count range check wins over the negative-left check
          if ((sgn && b[63]) || b >= w) begin
            st = cia_pkg::ST_SHIFT;
          end else if (q.command == cia_pkg::CMD_SHL) begin
            maxv = sgn ? (mask >> 1) : mask;
            if (sgn && a[63]) st = cia_pkg::ST_OVF;
            else if (b != 0 && a > (maxv >> b)) st = cia_pkg::ST_OVF;
            else r = a << b;
          end else if (sgn && a[63]) begin
            r = ~((~a) >> b);
          end else begin
            r = a >> b;
          end
        end
        cia_pkg::CMD_LT: begin
          r = sgn ? ((a ^ cia_pkg::SIGN64) < (b ^ cia_pkg::SIGN64)) : (a < b);
          boolean = 1'b1;
        end
        cia_pkg::CMD_LE: begin
          r = sgn ? ((a ^ cia_pkg::SIGN64) <= (b ^ cia_pkg::SIGN64)) : (a <= b);
          boolean = 1'b1;
        end
        cia_pkg::CMD_GT: begin
          r = sgn ? ((a ^ cia_pkg::SIGN64) > (b ^ cia_pkg::SIGN64)) : (a > b);
          boolean = 1'b1;
        end
        cia_pkg::CMD_GE: begin
          r = sgn ? ((a ^ cia_pkg::SIGN64) >= (b ^ cia_pkg::SIGN64)) : (a >= b);
          boolean = 1'b1;
        end
        cia_pkg::CMD_EQ: begin r = (a == b); boolean = 1'b1; end
        cia_pkg::CMD_NE: begin r = (a != b); boolean = 1'b1; end
        cia_pkg::CMD_NEG: begin
          if (!sgn) begin
            if (a != 0) st = cia_pkg::ST_OVF;
          end else if (a == cia_pkg::SIGN64) begin
            st = cia_pkg::ST_OVF;
          end else begin
            r = -a;
          end
        end
        cia_pkg::CMD_NOT: r = sgn ? ~a : (~a & mask);
        default: st = cia_pkg::ST_OVF;
      endcase
      // range check on the full-width result
      if (st == cia_pkg::ST_OK && !boolean) begin
        if (sgn ? sign_fill(r, q.width_select) != r : (r & ~mask) != 0) st = cia_pkg::ST_OVF;
      end
      if (st != cia_pkg::ST_OK) begin
        r = '0;
        boolean = 1'b0;
      end
      o.result_value = r & mask;
      o.is_boolean = boolean;
      o.status = st;
      return o;
    endfunction

    function void note_request(cia_pkg::req_t q);
      expected_q.push_back(predict_alu(q));
    endfunction

    function void check_response(cia_pkg::rsp_t got);
      cia_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected response transaction: result_value %h", got.result_value);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.result_value !== want.result_value) begin
        $error("result_value expected %h actual %h", want.result_value, got.result_value);
        errors++;
      end
      if (got.is_boolean !== want.is_boolean) begin
        $error("is_boolean expected %b actual %b", want.is_boolean, got.is_boolean);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d actual %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  result_scoreboard sb = new();
  bit stimulus_done = 1'b0;
  int cmd_seen[32];

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
  end

  function automatic cia_pkg::req_t make_op(logic [4:0] cmd, logic sgn, logic [1:0] wsel,
                                            logic [63:0] a, logic [63:0] b);
    cia_pkg::req_t q;
    q.command = cmd;
    q.is_signed = sgn;
    q.width_select = wsel;
    q.left_operand = a;
    q.right_operand = b;
    return q;
  endfunction

  // Operand biased toward the edges of the selected width, with random upper bits now and then.
  function automatic logic [63:0] pick_operand(logic [1:0] wsel);
    int w;
    logic [63:0] top;
    w = 8 << wsel;
    top = (wsel == 2'd3) ? '1 : ((64'd1 << w) - 64'd1);
    case ($urandom_range(0, 8))
      0: return '0;
      1: return 64'd1;
      2: return '1;
      3: return 64'd1 << (w - 1);
      4: return top >> 1;
      5: return $urandom_range(0, 20);
      6: return -$urandom_range(1, 20);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Drives one request transaction after a random gap; returns once it is taken.
  task automatic send_request(cia_pkg::req_t q);
    int gap;
    gap = $urandom_range(0, 17);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= q;
    do @(posedge clk); while (!req.ready);
    sb.note_request(q);
    cmd_seen[q.command]++;
    @(negedge clk);
  endtask

  // Response side: random hold-off before each transaction.
  initial begin : response_sink
    int gap;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 17);
      // roughly a quarter of the time run flat out
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      sb.check_response(rsp.payload);
      @(negedge clk);
    end
  end

  // Hang detection: no transaction on either side for too long.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= HANG_LIMIT) begin
        $display("timeout with %0d responses outstanding", sb.expected_q.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin : request_driver
    cia_pkg::req_t q;
    logic [1:0] wsel;
    int distinct;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed corner cases.
    // signed 8-bit overflow
    send_request(make_op(cia_pkg::CMD_ADD, 1, 0, 64'h7F, 64'h01));
    // unsigned wrap
    send_request(make_op(cia_pkg::CMD_ADD, 0, 3, '1, 64'd1));
    // unsigned borrow
    send_request(make_op(cia_pkg::CMD_SUB, 0, 1, 64'd0, 64'd1));
    // signed MIN - 1
    send_request(make_op(cia_pkg::CMD_SUB, 1, 3, cia_pkg::SIGN64, 64'd1));
    // 64-bit product too big
    send_request(make_op(cia_pkg::CMD_MUL, 0, 3, '1, 64'd2));
    // exactly MIN at 32 bits
    send_request(make_op(cia_pkg::CMD_MUL, 1, 2, 64'hFFFF_0000, 64'h0000_8000));
    // zero divisor
    send_request(make_op(cia_pkg::CMD_DIV, 1, 2, 64'h1234, 64'd0));
    // zero after masking
    send_request(make_op(cia_pkg::CMD_REM, 0, 0, 64'h55, 64'hFF00));
    // MIN / -1
    send_request(make_op(cia_pkg::CMD_DIV, 1, 3, cia_pkg::SIGN64, '1));
    // MIN % -1 is zero
    send_request(make_op(cia_pkg::CMD_REM, 1, 3, cia_pkg::SIGN64, '1));
    // remainder follows dividend
    send_request(make_op(cia_pkg::CMD_REM, 1, 1, 64'hFFF9, 64'd2));
    // negative left value
    send_request(make_op(cia_pkg::CMD_SHL, 1, 1, 64'hFFFF, 64'd1));
    // count equals width
    send_request(make_op(cia_pkg::CMD_SHL, 0, 0, 64'h01, 64'd8));
    // negative count beats negative value
    send_request(make_op(cia_pkg::CMD_SHL, 1, 0, 64'h80, 64'hFF));
    // bit past max positive
    send_request(make_op(cia_pkg::CMD_SHL, 1, 0, 64'h20, 64'd2));
    // arithmetic shift
    send_request(make_op(cia_pkg::CMD_SHR, 1, 2, 64'h8000_0000, 64'd31));
    // logical shift
    send_request(make_op(cia_pkg::CMD_SHR, 0, 2, 64'h8000_0000, 64'd31));
    // unsigned negate of zero
    send_request(make_op(cia_pkg::CMD_NEG, 0, 3, 64'd0, 64'd0));
    // unsigned negate nonzero
    send_request(make_op(cia_pkg::CMD_NEG, 0, 3, 64'd5, 64'd0));
    // negate MIN
    send_request(make_op(cia_pkg::CMD_NEG, 1, 0, 64'h80, 64'd0));
    send_request(make_op(cia_pkg::CMD_NOT, 0, 1, 64'hFFFF_FFFF_0000_1234, 64'd0));
    send_request(make_op(cia_pkg::CMD_LT, 1, 0, 64'h80, 64'h7F));
    send_request(make_op(cia_pkg::CMD_GE, 0, 0, 64'h80, 64'h7F));
    send_request(make_op(cia_pkg::CMD_XOR, 1, 3, '1, 64'h0F0F));
    // undefined command
    send_request(make_op(5'd31, 0, 2, 64'd1, 64'd1));

    // Let the pipeline drain completely before the random part.
    req.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      wsel = $urandom_range(0, 3);
      q.width_select = wsel;
      q.is_signed = $urandom_range(0, 1);
      q.command = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                                                : 5'($urandom_range(0, 17));
      q.left_operand = pick_operand(wsel);
      q.right_operand = pick_operand(wsel);
      // keep most shift counts near the legal range
      if ((q.command == cia_pkg::CMD_SHL || q.command == cia_pkg::CMD_SHR) &&
          $urandom_range(0, 3) != 0)
        q.right_operand = $urandom_range(0, (8 << wsel) + 2);
      send_request(q);
    end
    req.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    distinct = 0;
    for (int c = 0; c < 32; c++) if (cmd_seen[c] != 0) distinct++;
    $display("checked %0d responses across %0d distinct command codes,", sb.checked, distinct);
    $display("all four widths, signed and unsigned, with random stalls on both channels");
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

[sim.f]
src/cia_pkg.sv
src/cia_chan_if.sv
src/cia_front.sv
src/cia_divider.sv
src/checked_integer_alu_unit.sv
tb/checked_integer_alu_unit_test.sv
